>>> src/ape_pkg.sv
// ---------------------------------------------------------------------------
// ape_pkg
// Shared constants, types and byte helpers for the ARP proxy / Ethernet
// encapsulation block.
// ---------------------------------------------------------------------------
package ape_pkg;

    // Frame geometry
    localparam int HOLD_DEPTH  = 42;
    localparam int IP_HOLD     = 20;
    localparam int ETH_LEN     = 14;
    localparam int ARP_FRAME   = 42;
    localparam int ENC_HDR_LEN = ETH_LEN + IP_HOLD;

    // Configuration register indexes
    localparam logic [1:0] REG_ENABLE  = 2'd0;
    localparam logic [1:0] REG_OWN_MAC = 2'd1;
    localparam logic [1:0] REG_OWN_IP  = 2'd2;

    // Packet modes
    localparam logic [2:0] MODE_IDLE     = 3'd0;
    localparam logic [2:0] MODE_ENC_HOLD = 3'd1;
    localparam logic [2:0] MODE_DEC_HOLD = 3'd2;
    localparam logic [2:0] MODE_ENC_PASS = 3'd3;
    localparam logic [2:0] MODE_DEC_PASS = 3'd4;
    localparam logic [2:0] MODE_DISCARD  = 3'd5;

    // Generated frame kinds
    localparam logic [1:0] KIND_ENC_ARP   = 2'd0;
    localparam logic [1:0] KIND_ENC_HDR   = 2'd1;
    localparam logic [1:0] KIND_DEC_REPLY = 2'd2;
    localparam logic [1:0] KIND_DUMP      = 2'd3;

    // ARP operation codes
    localparam logic [7:0] ARP_OP_REQUEST = 8'h01;
    localparam logic [7:0] ARP_OP_REPLY   = 8'h02;

    // Control handed from the sequencer to the byte selector
    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] len;
        logic       last;
        logic       link;
        logic [3:0] ver;
    } gen_ctrl_t;

    // Byte i (0 = most significant) of a 48-bit address
    function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [5:0] i);
        logic [7:0] b;
        begin
            unique case (i)
                6'd0:    b = mac[47:40];
                6'd1:    b = mac[39:32];
                6'd2:    b = mac[31:24];
                6'd3:    b = mac[23:16];
                6'd4:    b = mac[15:8];
                default: b = mac[7:0];
            endcase
            return b;
        end
    endfunction

    // Bytes 12..21 of an ARP frame: ethertype, hardware/protocol types, sizes, op
    function automatic logic [7:0] arp_body(input logic [5:0] k, input logic [7:0] oper);
        logic [7:0] b;
        begin
            unique case (k)
                6'd12:   b = 8'h08;
                6'd13:   b = 8'h06;
                6'd14:   b = 8'h00;
                6'd15:   b = 8'h01;
                6'd16:   b = 8'h08;
                6'd17:   b = 8'h00;
                6'd18:   b = 8'h06;
                6'd19:   b = 8'h04;
                6'd20:   b = 8'h00;
                default: b = oper;
            endcase
            return b;
        end
    endfunction

    // Hold buffer address feeding output byte k of a generated frame
    function automatic logic [5:0] src_addr(input logic [1:0] kind, input logic [5:0] k);
        logic [5:0] a;
        begin
            unique case (kind)
                KIND_ENC_ARP:   a = (k < 6'd32) ? k - 6'd16 : k - 6'd22;
                KIND_ENC_HDR:   a = k - 6'd14;
                KIND_DEC_REPLY: a = (k < 6'd32) ? k + 6'd10 : k - 6'd10;
                default:        a = k;
            endcase
            return a;
        end
    endfunction

endpackage

>>> src/ape_frame_sel.sv
// ---------------------------------------------------------------------------
// ape_frame_sel
// Picks output byte k of a generated frame from constants, addresses and
// the hold buffer read data.
// ---------------------------------------------------------------------------
module ape_frame_sel (
    input  ape_pkg::gen_ctrl_t ctrl,
    input  logic [5:0]         k,
    input  logic [47:0]        own_mac,
    input  logic [47:0]        peer_mac,
    input  logic [7:0]         mem_data,
    output logic [7:0]         frame_byte
);

    logic       v4;
    logic [7:0] etype_hi;
    logic [7:0] etype_lo;

    // Ethertype from the IP version nibble
    always_comb
    begin
        v4 = (ctrl.ver == 4'd4);
        etype_hi = 8'h00;
        etype_lo = 8'h00;
        if (v4)
        begin
            etype_hi = 8'h08;
        end
        else if (ctrl.ver == 4'd6)
        begin
            etype_hi = 8'h86;
            etype_lo = 8'hDD;
        end
    end

    // Select the byte by frame kind and position
    always_comb
    begin
        frame_byte = 8'h00;
        unique case (ctrl.kind)
            ape_pkg::KIND_ENC_ARP:
            begin
                priority if (k < 6'd6)  frame_byte = 8'hFF;
                else if (k < 6'd12) frame_byte = ape_pkg::mac_byte(own_mac, k - 6'd6);
                else if (k < 6'd22) frame_byte = ape_pkg::arp_body(k, ape_pkg::ARP_OP_REQUEST);
                else if (k < 6'd28) frame_byte = ape_pkg::mac_byte(own_mac, k - 6'd22);
                else if (k < 6'd32) frame_byte = v4 ? mem_data : 8'h00;
                else if (k < 6'd38) frame_byte = 8'h00;
                else                frame_byte = v4 ? mem_data : 8'h00;
            end
            ape_pkg::KIND_ENC_HDR:
            begin
                priority if (k < 6'd6)  frame_byte = ape_pkg::mac_byte(peer_mac, k);
                else if (k < 6'd12) frame_byte = ape_pkg::mac_byte(own_mac, k - 6'd6);
                else if (k == 6'd12) frame_byte = etype_hi;
                else if (k == 6'd13) frame_byte = etype_lo;
                else                 frame_byte = mem_data;
            end
            ape_pkg::KIND_DEC_REPLY:
            begin
                priority if (k < 6'd6)  frame_byte = ape_pkg::mac_byte(peer_mac, k);
                else if (k < 6'd12) frame_byte = ape_pkg::mac_byte(own_mac, k - 6'd6);
                else if (k < 6'd22) frame_byte = ape_pkg::arp_body(k, ape_pkg::ARP_OP_REPLY);
                else if (k < 6'd28) frame_byte = ape_pkg::mac_byte(own_mac, k - 6'd22);
                else                frame_byte = mem_data;
            end
            default:
            begin
                frame_byte = mem_data;
            end
        endcase
    end

endmodule

>>> src/arp_proxy_ethernet_encap.sv
// ---------------------------------------------------------------------------
// arp_proxy_ethernet_encap
// ARP proxy with Ethernet encapsulation for a point-to-point IP tunnel.
// ---------------------------------------------------------------------------
// Input words (op, in_byte, in_last) and output words (out_byte, out_last,
// to_link, dropped) use valid/ready. Registers are written through
// cfg_we/cfg_index/cfg_data: 0 enable, 1 own_mac, 2 own_ip.
// A word that produces one output (pass-through, disabled, drop marker) is
// taken and its result sits in the output register the next cycle. Held
// words produce nothing. When a decision point is reached, a generated
// frame (34 to 42 bytes) or a dump of the held bytes follows, each byte
// first read from the hold buffer and then loaded into the output
// register once it is free. in_ready stays low while a frame is generated.
// A new word is accepted only once the output register is empty or is taken
// by the receiver in the same cycle. Reset clears mode, counters, learned
// peer address and the registers; the hold buffer is not cleared. When the
// receiver stalls, the output register holds, the generator waits and
// in_ready stays low.
// ---------------------------------------------------------------------------
module arp_proxy_ethernet_encap (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        out_last,
    output logic        to_link,
    output logic        dropped
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_LOAD  = 2'd2;

    logic                enable_reg;
    logic [47:0]         own_mac_reg;
    logic [31:0]         own_ip_reg;
    logic [47:0]         peer_mac_reg;
    logic [2:0]          mode_reg;
    logic [5:0]          count_reg;
    logic [1:0]          state_reg;
    logic [5:0]          k_reg;
    ape_pkg::gen_ctrl_t  ctrl_reg;
    logic [3:0]          ver_reg;
    logic [47:0]         mac_sh_reg;
    logic                t12_reg;
    logic                op_hi_reg;
    logic                op_ok_reg;
    logic [23:0]         tpa_sh_reg;
    logic [7:0]          hold_mem [0:ape_pkg::HOLD_DEPTH-1];
    logic [7:0]          rd_data_reg;
    logic                out_valid_reg;
    logic [7:0]          out_byte_reg;
    logic                out_last_reg;
    logic                to_link_reg;
    logic                dropped_reg;

    logic                out_free;
    logic                accept;
    logic [2:0]          mode_eff;
    logic [5:0]          cnt_eff;
    logic [5:0]          cnt_new;
    logic [5:0]          rd_addr;
    logic [7:0]          gen_byte;
    logic [31:0]         tpa_full;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign to_link   = to_link_reg;
    assign dropped   = dropped_reg;

    // Effective mode and count for the word being taken
    always_comb
    begin
        mode_eff = mode_reg;
        cnt_eff  = count_reg;
        if (mode_reg == ape_pkg::MODE_IDLE)
        begin
            mode_eff = op ? ape_pkg::MODE_DEC_HOLD : ape_pkg::MODE_ENC_HOLD;
            cnt_eff  = 6'd0;
        end
        cnt_new  = (cnt_eff < 6'(ape_pkg::HOLD_DEPTH)) ? cnt_eff + 6'd1 : cnt_eff;
        tpa_full = {tpa_sh_reg, in_byte};
        rd_addr  = ape_pkg::src_addr(ctrl_reg.kind, k_reg);
    end

    ape_frame_sel u_sel (
        .ctrl       (ctrl_reg),
        .k          (k_reg),
        .own_mac    (own_mac_reg),
        .peer_mac   (peer_mac_reg),
        .mem_data   (rd_data_reg),
        .frame_byte (gen_byte)
    );

    // Hold buffer: write on held words, registered read while generating
    always_ff @(posedge clk)
    begin
        if (accept && enable_reg && cnt_eff < 6'(ape_pkg::HOLD_DEPTH)
            && (mode_eff == ape_pkg::MODE_ENC_HOLD || mode_eff == ape_pkg::MODE_DEC_HOLD))
        begin
            hold_mem[cnt_eff] <= in_byte;
        end
        if (state_reg == ST_FETCH && rd_addr < 6'(ape_pkg::HOLD_DEPTH))
        begin
            rd_data_reg <= hold_mem[rd_addr];
        end
    end

    // Header field capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept && enable_reg)
        begin
            if (mode_eff == ape_pkg::MODE_ENC_HOLD && cnt_eff == 6'd0)
            begin
                ver_reg <= in_byte[7:4];
            end
            if (mode_eff == ape_pkg::MODE_DEC_HOLD)
            begin
                if (cnt_eff >= 6'd6 && cnt_eff < 6'd12)
                begin
                    mac_sh_reg <= {mac_sh_reg[39:0], in_byte};
                end
                if (cnt_eff == 6'd12) t12_reg   <= (in_byte == 8'h08);
                if (cnt_eff == 6'd20) op_hi_reg <= (in_byte == 8'h00);
                if (cnt_eff == 6'd21) op_ok_reg <= op_hi_reg && (in_byte == 8'h01);
                if (cnt_eff >= 6'd38 && cnt_eff < 6'd41)
                begin
                    tpa_sh_reg <= {tpa_sh_reg[15:0], in_byte};
                end
            end
        end
    end

    // Configuration, packet sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            own_mac_reg   <= '0;
            own_ip_reg    <= '0;
            peer_mac_reg  <= '0;
            mode_reg      <= ape_pkg::MODE_IDLE;
            count_reg     <= '0;
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            ctrl_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            out_last_reg  <= 1'b0;
            to_link_reg   <= 1'b0;
            dropped_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    ape_pkg::REG_ENABLE:  enable_reg  <= cfg_data[0];
                    ape_pkg::REG_OWN_MAC: own_mac_reg <= cfg_data;
                    ape_pkg::REG_OWN_IP:  own_ip_reg  <= cfg_data[31:0];
                    default:              ;
                endcase
            end

            // Drain the output register
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (!enable_reg)
                        begin
                            mode_reg      <= ape_pkg::MODE_IDLE;
                            count_reg     <= '0;
                            out_valid_reg <= 1'b1;
                            out_byte_reg  <= in_byte;
                            out_last_reg  <= in_last;
                            to_link_reg   <= !op;
                            dropped_reg   <= 1'b0;
                        end
                        else if (mode_eff == ape_pkg::MODE_ENC_PASS
                                 || mode_eff == ape_pkg::MODE_DEC_PASS)
                        begin
                            out_valid_reg <= 1'b1;
                            out_byte_reg  <= in_byte;
                            out_last_reg  <= in_last;
                            to_link_reg   <= (mode_eff == ape_pkg::MODE_ENC_PASS);
                            dropped_reg   <= 1'b0;
                            if (in_last) mode_reg <= ape_pkg::MODE_IDLE;
                        end
                        else if (mode_eff == ape_pkg::MODE_DISCARD)
                        begin
                            if (in_last) mode_reg <= ape_pkg::MODE_IDLE;
                        end
                        else
                        begin
                            // Holding: advance the count and check decision points
                            mode_reg  <= mode_eff;
                            count_reg <= cnt_new;
                            k_reg     <= '0;
                            if (mode_eff == ape_pkg::MODE_ENC_HOLD
                                && cnt_new >= 6'(ape_pkg::IP_HOLD))
                            begin
                                ctrl_reg.kind <= (peer_mac_reg == '0) ? ape_pkg::KIND_ENC_ARP
                                                                     : ape_pkg::KIND_ENC_HDR;
                                ctrl_reg.len  <= (peer_mac_reg == '0)
                                                 ? 6'(ape_pkg::ARP_FRAME)
                                                 : 6'(ape_pkg::ENC_HDR_LEN);
                                ctrl_reg.last <= (peer_mac_reg == '0) ? 1'b1 : in_last;
                                ctrl_reg.link <= 1'b1;
                                ctrl_reg.ver  <= (cnt_eff == 6'd0) ? in_byte[7:4] : ver_reg;
                                state_reg     <= ST_FETCH;
                                if (in_last)
                                    mode_reg <= ape_pkg::MODE_IDLE;
                                else if (peer_mac_reg == '0)
                                    mode_reg <= ape_pkg::MODE_DISCARD;
                                else
                                    mode_reg <= ape_pkg::MODE_ENC_PASS;
                                if (in_last) count_reg <= '0;
                            end
                            else if (mode_eff == ape_pkg::MODE_DEC_HOLD
                                     && cnt_new == 6'(ape_pkg::ETH_LEN))
                            begin
                                // Learn the sender address; strip non-ARP headers
                                peer_mac_reg <= mac_sh_reg;
                                if (!(t12_reg && in_byte == 8'h06))
                                begin
                                    count_reg <= '0;
                                    if (in_last)
                                    begin
                                        mode_reg      <= ape_pkg::MODE_IDLE;
                                        out_valid_reg <= 1'b1;
                                        out_byte_reg  <= 8'h00;
                                        out_last_reg  <= 1'b1;
                                        to_link_reg   <= 1'b0;
                                        dropped_reg   <= 1'b1;
                                    end
                                    else
                                    begin
                                        mode_reg <= ape_pkg::MODE_DEC_PASS;
                                    end
                                end
                                else if (in_last)
                                begin
                                    ctrl_reg.kind <= ape_pkg::KIND_DUMP;
                                    ctrl_reg.len  <= cnt_new;
                                    ctrl_reg.last <= 1'b1;
                                    ctrl_reg.link <= 1'b0;
                                    state_reg     <= ST_FETCH;
                                    mode_reg      <= ape_pkg::MODE_IDLE;
                                    count_reg     <= '0;
                                end
                            end
                            else if (mode_eff == ape_pkg::MODE_DEC_HOLD
                                     && cnt_new >= 6'(ape_pkg::ARP_FRAME))
                            begin
                                mode_reg  <= in_last ? ape_pkg::MODE_IDLE
                                                     : ape_pkg::MODE_DISCARD;
                                count_reg <= '0;
                                if (op_ok_reg && tpa_full == own_ip_reg)
                                begin
                                    ctrl_reg.kind <= ape_pkg::KIND_DEC_REPLY;
                                    ctrl_reg.len  <= 6'(ape_pkg::ARP_FRAME);
                                    ctrl_reg.last <= 1'b1;
                                    ctrl_reg.link <= 1'b1;
                                    state_reg     <= ST_FETCH;
                                end
                                else
                                begin
                                    out_valid_reg <= 1'b1;
                                    out_byte_reg  <= 8'h00;
                                    out_last_reg  <= 1'b1;
                                    to_link_reg   <= 1'b0;
                                    dropped_reg   <= 1'b1;
                                end
                            end
                            else if (in_last)
                            begin
                                // Short packet: dump the held bytes unchanged
                                ctrl_reg.kind <= ape_pkg::KIND_DUMP;
                                ctrl_reg.len  <= cnt_new;
                                ctrl_reg.last <= 1'b1;
                                ctrl_reg.link <= (mode_eff == ape_pkg::MODE_ENC_HOLD);
                                state_reg     <= ST_FETCH;
                                mode_reg      <= ape_pkg::MODE_IDLE;
                                count_reg     <= '0;
                            end
                        end
                    end
                end
                ST_FETCH:
                begin
                    state_reg <= ST_LOAD;
                end
                ST_LOAD:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_byte_reg  <= gen_byte;
                        out_last_reg  <= (k_reg == ctrl_reg.len - 6'd1) ? ctrl_reg.last : 1'b0;
                        to_link_reg   <= ctrl_reg.link;
                        dropped_reg   <= 1'b0;
                        k_reg         <= k_reg + 6'd1;
                        state_reg     <= (k_reg == ctrl_reg.len - 6'd1) ? ST_IDLE : ST_FETCH;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
